FILE: rtl/core/lfso_pkg.sv
// shared types and constants of the linear-fit slot occupancy unit
`timescale 1ns / 1ps
package lfso_pkg;

  localparam int unsigned BIG_W = 256;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned OUT_W = 16;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_K0,
    OP_XSUM,
    OP_XMAP,
    OP_M_XX,
    OP_M_XI,
    OP_M_NXY,
    OP_M_XY,
    OP_M_NXX,
    OP_M_SXSX,
    OP_M_YD,
    OP_M_NUMX,
    OP_M_NDEN,
    OP_M_NNUM,
    OP_M_TX,
    OP_M_P,
    OP_W_XX,
    OP_W_XY,
    OP_W_TMP,
    OP_W_NUM,
    OP_W_DEN,
    OP_W_ICP,
    OP_W_NDEN,
    OP_W_NNUM,
    OP_W_T,
    OP_W_P,
    OP_SKIP,
    OP_MARK,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic idx_last;
    logic den_ok;
    logic t_neg;
    logic cand_ok;
    logic bit_zero;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/core/linear_fit_slot_occupancy_unit.sv
// top level of the linear-fit slot occupancy unit
`timescale 1ns / 1ps
// collects a batch of ascending 64-bit keys (tlast marks the final key), fits an exact
// least-squares line from key offset to rank in 256-bit wrapping integer arithmetic, maps
// each key to a floored slot clamped to 0..n-1 and posts one item with the occupied slot
// count, the colliding key count and an overflow flag. keys load at one per cycle; keys
// past MAX_BATCH are dropped and flagged. after the last key the block stops accepting
// while a single shift-add multiplier, one multiplier bit per cycle, runs the passes:
// per key the offset square and the offset-rank product for the sums; eight fit products,
// with the batch size or n(n-1)/2 as serial operand for six of them and the offset sum
// (up to 64 + log2(MAX_BATCH) bits) for the other two; then per key the offset product
// plus up to log2(MAX_BATCH) search steps, each a candidate product unless the candidate
// is past n-1, and a step to mark the slot. the result is then posted, and the block
// waits there while the previous result item is still not taken.
module linear_fit_slot_occupancy_unit #(
  parameter int unsigned MAX_BATCH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // key
  input  logic        s_axis_tlast_i,   // last_key
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // occupied_slots[7:0], colliding_keys[14:8],
                                        // batch_overflow[15]
);
  import lfso_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: owns the phase order, the datapath only obeys commands
  lfso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage, accumulators, multiplier and the output register
  lfso_datapath #(
    .MAX_BATCH (MAX_BATCH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .key_i       (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

FILE: rtl/core/lfso_datapath.sv
// key store, wide accumulators, bit-serial multiplier and result register
`timescale 1ns / 1ps
module lfso_datapath #(
  parameter int unsigned MAX_BATCH = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfso_pkg::dp_cmd_t        cmd_i,
  output lfso_pkg::dp_stat_t       stat_o,
  input  logic [lfso_pkg::KEY_W-1:0] key_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [lfso_pkg::OUT_W-1:0] out_data_o
);
  import lfso_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_BATCH);
  localparam int unsigned CW  = $clog2(MAX_BATCH + 1);
  localparam int unsigned BTW = (AW > 1) ? $clog2(AW) : 1;

  logic [KEY_W-1:0] mem [MAX_BATCH];
  logic [KEY_W-1:0] rdata_q;

  logic [CW-1:0]  count_q, count_d, idx_q, idx_d, occ_q, occ_d;
  logic           ovf_q, ovf_d, oval_q, oval_d;
  logic [OUT_W-1:0] odata_q, odata_d;
  logic [MAX_BATCH-1:0] slot_q, slot_d;
  logic [AW-1:0]  q_q, q_d;
  logic [BTW-1:0] bit_q, bit_d;
  logic [KEY_W-1:0] k0_q, k0_d, x_q, x_d;
  logic [BIG_W-1:0] sx_q, sx_d, sxx_q, sxx_d, sxy_q, sxy_d, tmp_q, tmp_d;
  logic [BIG_W-1:0] num_q, num_d, den_q, den_d, icp_q, icp_d;
  logic [BIG_W-1:0] nden_q, nden_d, nnum_q, nnum_d, t_q, t_d;
  logic [BIG_W-1:0] ma_q, ma_d, mb_q, mb_d, acc_q, acc_d;
  logic [BIG_W-1:0] sel_a, sel_b, n_big, y_big;
  logic [2*CW-1:0]  nn1;
  logic [AW:0]      cand;
  logic [KEY_W-1:0] xoff;
  logic             start;

  assign nn1   = (2*CW)'(count_q) * (2*CW)'(count_q - CW'(1));
  assign n_big = BIG_W'(count_q);
  assign y_big = BIG_W'(nn1 >> 1);
  assign cand  = (AW+1)'(q_q) + ((AW+1)'(1) << bit_q);
  assign xoff  = rdata_q - k0_q;

  assign stat_o.mul_done = (mb_q == '0);
  assign stat_o.idx_last = (idx_q == count_q - CW'(1));
  assign stat_o.den_ok   = (den_q != '0) && !den_q[BIG_W-1];
  assign stat_o.t_neg    = t_q[BIG_W-1];
  assign stat_o.cand_ok  = (32'(cand) < 32'(count_q));
  assign stat_o.bit_zero = (bit_q == '0);
  assign stat_o.out_busy = oval_q;

  assign out_valid_o = oval_q;
  assign out_data_o  = odata_q;

  // multiplier operand selection, small operand on the serial side
  always_comb begin
    start = 1'b1;
    sel_a = '0;
    sel_b = '0;
    unique case (cmd_i.op)
      OP_M_XX:   begin sel_a = BIG_W'(x_q);  sel_b = BIG_W'(x_q); end
      OP_M_XI:   begin sel_a = BIG_W'(x_q);  sel_b = BIG_W'(idx_q); end
      OP_M_NXY:  begin sel_a = sxy_q; sel_b = n_big; end
      OP_M_XY:   begin sel_a = sx_q;  sel_b = y_big; end
      OP_M_NXX:  begin sel_a = sxx_q; sel_b = n_big; end
      OP_M_SXSX: begin sel_a = sx_q;  sel_b = sx_q; end
      OP_M_YD:   begin sel_a = den_q; sel_b = y_big; end
      OP_M_NUMX: begin sel_a = num_q; sel_b = sx_q; end
      OP_M_NDEN: begin sel_a = den_q; sel_b = n_big; end
      OP_M_NNUM: begin sel_a = num_q; sel_b = n_big; end
      OP_M_TX:   begin sel_a = nnum_q; sel_b = BIG_W'(x_q); end
      OP_M_P:    begin sel_a = nden_q; sel_b = BIG_W'(cand); end
      default:   start = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q; idx_d = idx_q; occ_d = occ_q; ovf_d = ovf_q;
    oval_d = oval_q; odata_d = odata_q; slot_d = slot_q; q_d = q_q; bit_d = bit_q;
    k0_d = k0_q; x_d = x_q; sx_d = sx_q; sxx_d = sxx_q; sxy_d = sxy_q; tmp_d = tmp_q;
    num_d = num_q; den_d = den_q; icp_d = icp_q; nden_d = nden_q; nnum_d = nnum_q;
    t_d = t_q; ma_d = ma_q; mb_d = mb_q; acc_d = acc_q;

    if (oval_q && out_ready_i) oval_d = 1'b0;

    if (start) begin
      ma_d = sel_a; mb_d = sel_b; acc_d = '0;
    end else if (mb_q != '0) begin
      if (mb_q[0]) acc_d = acc_q + ma_q;
      ma_d = ma_q << 1;
      mb_d = mb_q >> 1;
    end

    unique case (cmd_i.op)
      OP_LOAD: begin
        if (count_q < CW'(MAX_BATCH)) count_d = count_q + CW'(1);
        else ovf_d = 1'b1;
      end
      OP_K0: begin
        k0_d = rdata_q; sx_d = '0; sxx_d = '0; sxy_d = '0;
      end
      OP_XSUM: begin
        x_d = xoff; sx_d = sx_q + BIG_W'(xoff);
      end
      OP_XMAP:   x_d = xoff;
      OP_W_XX:   sxx_d = sxx_q + acc_q;
      OP_W_XY: begin
        sxy_d = sxy_q + acc_q; idx_d = idx_q + CW'(1);
      end
      OP_W_TMP:  tmp_d = acc_q;
      OP_W_NUM:  num_d = tmp_q - acc_q;
      OP_W_DEN:  den_d = tmp_q - acc_q;
      OP_W_ICP:  icp_d = tmp_q - acc_q;
      OP_W_NDEN: nden_d = acc_q;
      OP_W_NNUM: begin
        nnum_d = acc_q; idx_d = '0;
      end
      OP_W_T: begin
        t_d = acc_q + icp_q; q_d = '0; bit_d = BTW'(AW - 1);
      end
      OP_W_P: begin
        if (acc_q <= t_q) q_d = cand[AW-1:0];
        if (bit_q != '0) bit_d = bit_q - BTW'(1);
      end
      OP_SKIP: begin
        if (bit_q != '0) bit_d = bit_q - BTW'(1);
      end
      OP_MARK: begin
        if (!slot_q[q_q]) occ_d = occ_q + CW'(1);
        slot_d[q_q] = 1'b1;
        idx_d = idx_q + CW'(1);
      end
      OP_OUT: begin
        oval_d  = 1'b1;
        odata_d = {ovf_q, 7'(count_q - occ_q), 8'(occ_q)};
        count_d = '0; ovf_d = 1'b0; occ_d = '0; slot_d = '0; idx_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; idx_q <= '0; occ_q <= '0; ovf_q <= 1'b0;
      oval_q <= 1'b0; slot_q <= '0; mb_q <= '0;
    end else begin
      count_q <= count_d; idx_q <= idx_d; occ_q <= occ_d; ovf_q <= ovf_d;
      oval_q <= oval_d; slot_q <= slot_d; mb_q <= mb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d; q_q <= q_d; bit_q <= bit_d; k0_q <= k0_d; x_q <= x_d;
    sx_q <= sx_d; sxx_q <= sxx_d; sxy_q <= sxy_d; tmp_q <= tmp_d;
    num_q <= num_d; den_q <= den_d; icp_q <= icp_d; nden_q <= nden_d;
    nnum_q <= nnum_d; t_q <= t_d; ma_q <= ma_d; acc_q <= acc_d;
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && count_q < CW'(MAX_BATCH)) mem[count_q[AW-1:0]] <= key_i;
    rdata_q <= mem[idx_q[AW-1:0]];
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BATCH)) else $error("key count beyond capacity");
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_MARK |-> CW'(q_q) < count_q) else $error("slot beyond batch");
  a_occ_le_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= count_q) else $error("more slots than keys");
  a_out_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_OUT |=> oval_q && occ_q == '0) else $error("result not posted");

endmodule

FILE: rtl/core/lfso_ctrl.sv
// sequencer that steps the datapath through load, fit and mapping passes
`timescale 1ns / 1ps
module lfso_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  lfso_pkg::dp_stat_t  stat_i,
  output lfso_pkg::dp_cmd_t   cmd_o
);
  import lfso_pkg::*;

  typedef enum logic [33:0] {
    S_COLLECT = 34'd1 << 0,  S_RD0  = 34'd1 << 1,  S_K0   = 34'd1 << 2,
    S_RDX     = 34'd1 << 3,  S_X    = 34'd1 << 4,  S_MXX  = 34'd1 << 5,
    S_WXX     = 34'd1 << 6,  S_MXI  = 34'd1 << 7,  S_WXI  = 34'd1 << 8,
    S_M1      = 34'd1 << 9,  S_W1   = 34'd1 << 10, S_M2   = 34'd1 << 11,
    S_W2      = 34'd1 << 12, S_M3   = 34'd1 << 13, S_W3   = 34'd1 << 14,
    S_M4      = 34'd1 << 15, S_W4   = 34'd1 << 16, S_M5   = 34'd1 << 17,
    S_W5      = 34'd1 << 18, S_M6   = 34'd1 << 19, S_W6   = 34'd1 << 20,
    S_M7      = 34'd1 << 21, S_W7   = 34'd1 << 22, S_M8   = 34'd1 << 23,
    S_W8      = 34'd1 << 24, S_MRD  = 34'd1 << 25, S_MX   = 34'd1 << 26,
    S_MT      = 34'd1 << 27, S_WT   = 34'd1 << 28, S_SRCH = 34'd1 << 29,
    S_WP      = 34'd1 << 30, S_MARK = 34'd1 << 31, S_OUT  = 34'd1 << 32,
    S_SPARE   = 34'd1 << 33
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_COLLECT);

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_IDLE;
    unique case (state_q)
      S_COLLECT: if (in_valid_i) begin
        cmd_o.op = OP_LOAD;
        if (in_last_i) state_d = S_RD0;
      end
      S_RD0: state_d = S_K0;
      S_K0: begin cmd_o.op = OP_K0; state_d = S_RDX; end
      S_RDX: state_d = S_X;
      S_X:   begin cmd_o.op = OP_XSUM; state_d = S_MXX; end
      S_MXX: begin cmd_o.op = OP_M_XX; state_d = S_WXX; end
      S_WXX: if (stat_i.mul_done) begin cmd_o.op = OP_W_XX; state_d = S_MXI; end
      S_MXI: begin cmd_o.op = OP_M_XI; state_d = S_WXI; end
      S_WXI: if (stat_i.mul_done) begin
        cmd_o.op = OP_W_XY;
        state_d = stat_i.idx_last ? S_M1 : S_RDX;
      end
      S_M1: begin cmd_o.op = OP_M_NXY; state_d = S_W1; end
      S_W1: if (stat_i.mul_done) begin cmd_o.op = OP_W_TMP; state_d = S_M2; end
      S_M2: begin cmd_o.op = OP_M_XY; state_d = S_W2; end
      S_W2: if (stat_i.mul_done) begin cmd_o.op = OP_W_NUM; state_d = S_M3; end
      S_M3: begin cmd_o.op = OP_M_NXX; state_d = S_W3; end
      S_W3: if (stat_i.mul_done) begin cmd_o.op = OP_W_TMP; state_d = S_M4; end
      S_M4: begin cmd_o.op = OP_M_SXSX; state_d = S_W4; end
      S_W4: if (stat_i.mul_done) begin cmd_o.op = OP_W_DEN; state_d = S_M5; end
      S_M5: begin cmd_o.op = OP_M_YD; state_d = S_W5; end
      S_W5: if (stat_i.mul_done) begin cmd_o.op = OP_W_TMP; state_d = S_M6; end
      S_M6: begin cmd_o.op = OP_M_NUMX; state_d = S_W6; end
      S_W6: if (stat_i.mul_done) begin cmd_o.op = OP_W_ICP; state_d = S_M7; end
      S_M7: begin cmd_o.op = OP_M_NDEN; state_d = S_W7; end
      S_W7: if (stat_i.mul_done) begin cmd_o.op = OP_W_NDEN; state_d = S_M8; end
      S_M8: begin cmd_o.op = OP_M_NNUM; state_d = S_W8; end
      S_W8: if (stat_i.mul_done) begin cmd_o.op = OP_W_NNUM; state_d = S_MRD; end
      S_MRD: state_d = S_MX;
      S_MX:  begin cmd_o.op = OP_XMAP; state_d = S_MT; end
      S_MT:  begin cmd_o.op = OP_M_TX; state_d = S_WT; end
      S_WT:  if (stat_i.mul_done) begin cmd_o.op = OP_W_T; state_d = S_SRCH; end
      S_SRCH: begin
        priority if (!stat_i.den_ok || stat_i.t_neg) begin
          state_d = S_MARK;
        end else if (stat_i.cand_ok) begin
          cmd_o.op = OP_M_P; state_d = S_WP;
        end else begin
          cmd_o.op = OP_SKIP;
          if (stat_i.bit_zero) state_d = S_MARK;
        end
      end
      S_WP: if (stat_i.mul_done) begin
        cmd_o.op = OP_W_P;
        state_d = stat_i.bit_zero ? S_MARK : S_SRCH;
      end
      S_MARK: begin
        cmd_o.op = OP_MARK;
        state_d = stat_i.idx_last ? S_OUT : S_MRD;
      end
      S_OUT: if (!stat_i.out_busy) begin cmd_o.op = OP_OUT; state_d = S_COLLECT; end
      default: state_d = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_COLLECT;
    else state_q <= state_d;
  end

endmodule
